// File: hdl/slr_pkg.sv
// shared types and constants for the script line reader
package slr_pkg;

	localparam int LINE_UNITS = 512;

	localparam logic [8:0] POS_MASK_BYTE = 9'((LINE_UNITS - 1) & 'h1FF);
	localparam logic [8:0] POS_MASK_WIDE = 9'(((LINE_UNITS / 2) - 1) & 'h1FF);

	localparam logic [15:0] CH_CR    = 16'h000D;
	localparam logic [15:0] CH_LF    = 16'h000A;
	localparam logic [15:0] CH_QUOTE = 16'h0022;
	localparam logic [15:0] CH_SEMI  = 16'h003B;
	localparam logic [15:0] CH_TAB   = 16'h0009;
	localparam logic [15:0] CH_SPACE = 16'h0020;
	localparam logic [15:0] CH_NUL   = 16'h0000;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		CMT_NONE   = 2'd0,
		CMT_LEAD   = 2'd1,
		CMT_TRAIL  = 2'd2
	} cmt_mode_t;

	typedef enum logic {
		EV_CHAR = 1'b0,
		EV_LINE = 1'b1
	} event_kind_t;

	typedef struct packed {
		logic [15:0] char_count;
		logic        in_quotes;
		logic        has_content;
		logic        swallow_next;
		cmt_mode_t   comment_mode;
		logic [15:0] line_counter;
	} rd_state_t;

	typedef struct packed {
		event_kind_t event_kind;
		logic [15:0] char_out;
		logic [8:0]  position;
		logic [15:0] line_length;
		logic [15:0] line_number;
	} rd_result_t;

endpackage

// File: hdl/script_line_reader_core.sv
// top level of the script line reader: input stage, step logic, result register
//
//  port group   dir  handshake            payload
//  s_axis       in   s_tvalid/s_tready    s_tdata = char_unit, s_tlast = end_of_input
//  m_axis       out  m_tvalid/m_tready    m_tdata = result fields, m_tuser = event_kind
//  cfg          in   cfg_we               cfg_wdata = wide_chars
//
// one word per cycle while m_tready is high; a word is stepped from the input register
// into the result register once that is free or m_tready is high, then shown on m_tdata
// reset clears the line state, the mode register and both valid flags
// a stall on m_tready holds the result register, then the input register
module script_line_reader_core import slr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] char_unit
	input  logic        s_tlast,   // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [15:0] char_out, [24:16] position,
	                               // [40:25] line_length, [56:41] line_number, rest zero
	output logic        m_tuser    // event_kind
);

	logic        wide_q;
	rd_state_t   state_q;
	logic        valid_s1;
	logic [15:0] unit_s1;
	logic        eoi_s1;
	logic        valid_s2;
	rd_result_t  res_s2;

	rd_state_t   state_nxt;
	logic        emit;
	rd_result_t  result;
	logic        adv1;

	assign adv1 = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv1;

	slr_step u_step (
		.state       (state_q),
		.wide_chars  (wide_q),
		.char_unit   (unit_s1),
		.end_of_input(eoi_s1),
		.state_nxt   (state_nxt),
		.emit        (emit),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
		end else if (cfg_we) begin
			wide_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			unit_s1 <= s_tdata;
			eoi_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{char_count: 16'h0000, in_quotes: 1'b0, has_content: 1'b0,
				swallow_next: 1'b0, comment_mode: CMT_NONE, line_counter: 16'h0000};
			valid_s2 <= 1'b0;
		end else if (adv1) begin
			state_q <= state_nxt;
			valid_s2 <= emit;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && emit) begin
			res_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser = res_s2.event_kind;
	assign m_tdata = {7'h00, res_s2.line_number, res_s2.line_length,
		res_s2.position, res_s2.char_out};

endmodule

// File: hdl/slr_step.sv
// next-state and result logic for one text unit
module slr_step import slr_pkg::*; (
	input  rd_state_t   state,
	input  logic        wide_chars,
	input  logic [15:0] char_unit,
	input  logic        end_of_input,
	output rd_state_t   state_nxt,
	output logic        emit,
	output rd_result_t  result
);

	logic [15:0] c;
	logic [8:0]  pos;
	logic        at_end;

	always_comb begin
		c = end_of_input ? CH_NUL : (wide_chars ? char_unit : {8'h00, char_unit[7:0]});
		pos = state.char_count[8:0] & (wide_chars ? POS_MASK_WIDE : POS_MASK_BYTE);
		at_end = (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);

		state_nxt = state;
		emit = 1'b0;
		result.event_kind = EV_CHAR;
		result.char_out = CH_NUL;
		result.position = pos;
		result.line_length = 16'h0000;
		result.line_number = state.line_counter;

		// a unit after cr is dropped, end of text never is
		if (state.swallow_next && !end_of_input) begin
			state_nxt.swallow_next = 1'b0;
		end else begin
			state_nxt.swallow_next = (c == CH_CR);
			if (state.comment_mode != CMT_NONE) begin
				if (!at_end) begin
					state_nxt.swallow_next = 1'b0;
				end else if (state.comment_mode == CMT_TRAIL) begin
					emit = 1'b1;
				end else begin
					state_nxt.char_count = 16'h0000;
					state_nxt.has_content = 1'b0;
					state_nxt.comment_mode = CMT_NONE;
					state_nxt.line_counter = state.line_counter + 16'd1;
				end
			end else if ((c == CH_CR) || (c == CH_LF)) begin
				if ((state.char_count == 16'h0000) || !state.has_content) begin
					state_nxt.line_counter = state.line_counter + 16'd1;
					state_nxt.has_content = 1'b0;
				end else begin
					emit = 1'b1;
				end
			end else if (c == CH_NUL) begin
				emit = 1'b1;
			end else if ((c == CH_SEMI) && !state.in_quotes) begin
				state_nxt.comment_mode = ((state.char_count == 16'h0000) || !state.has_content)
					? CMT_LEAD : CMT_TRAIL;
			end else begin
				// character write
				emit = 1'b1;
				result.char_out = c;
				if (c == CH_QUOTE) begin
					state_nxt.in_quotes = ~state.in_quotes;
				end
				if ((c != CH_TAB) && (c != CH_SPACE)) begin
					state_nxt.has_content = 1'b1;
				end
				if (state.char_count != COUNT_MAX) begin
					state_nxt.char_count = state.char_count + 16'd1;
				end
			end

			// line completion, from a terminator or a trailing comment
			if (emit && (result.char_out == CH_NUL) && !(c != CH_NUL && !at_end)) begin
				result.event_kind = EV_LINE;
				result.line_length = state.char_count;
				state_nxt.char_count = 16'h0000;
				state_nxt.in_quotes = 1'b0;
				state_nxt.has_content = 1'b0;
				state_nxt.comment_mode = CMT_NONE;
				state_nxt.line_counter = state.line_counter + 16'd1;
			end
		end
	end

endmodule
